/* rtl/ksp_pkg.sv */
// ============================================================================
// ksp_pkg : kinematic state prediction shared types and constants
// Field widths, fixed-point angle constants and the CORDIC arctangent table.
// ============================================================================
package ksp_pkg;

    localparam int POS_W  = 48;
    localparam int ANG_W  = 31;
    localparam int WORD_W = 32;

    // Q3.28
    localparam logic signed [31:0] PI_Q28     = 32'sd843314857;
    localparam logic signed [31:0] TWO_PI_Q28 = 32'sd1686629713;
    // Q3.30
    localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

    // atan(2^-i), Q2.30, rounded to nearest
    localparam logic [31:0] ATAN_Q30 [32] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
        32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
        32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
        32'd262144,    32'd131072,    32'd65536,     32'd32768,
        32'd16384,     32'd8192,      32'd4096,      32'd2048,
        32'd1024,      32'd512,       32'd256,       32'd128,
        32'd64,        32'd32,        32'd16,        32'd8,
        32'd4,         32'd2,         32'd1,         32'd0
    };

    // number of compare/subtract steps reducing the predicted yaw mod 2pi
    localparam int RED_STEPS = 11;

    // values riding alongside the CORDIC stages
    typedef struct packed {
        logic [47:0] px;
        logic [47:0] py;
        logic [63:0] vdt;
        logic [31:0] dt;
        logic        flip;
        logic        is_pi;
    } t_side;

endpackage

/* rtl/ksp_if.sv */
// ============================================================================
// ksp_state_if / ksp_pred_if : valid/ready channels of the prediction core
// One interface for the state word in, one for the prediction word out.
// ============================================================================
interface ksp_state_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic signed [30:0] heading;
    logic signed [30:0] heading_bias;
    logic signed [31:0] speed;
    logic signed [31:0] turn_rate;
    logic        [31:0] time_step;

    modport source(output valid, pos_x, pos_y, heading, heading_bias, speed,
                   turn_rate, time_step, input ready);
    modport sink(input valid, pos_x, pos_y, heading, heading_bias, speed,
                 turn_rate, time_step, output ready);
endinterface

interface ksp_pred_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] next_x;
    logic signed [47:0] next_y;
    logic signed [30:0] next_heading;
    logic signed [47:0] dx_dyaw;
    logic signed [31:0] dx_dspeed;
    logic signed [47:0] dy_dyaw;
    logic signed [31:0] dy_dspeed;

    modport source(output valid, next_x, next_y, next_heading, dx_dyaw,
                   dx_dspeed, dy_dyaw, dy_dspeed, input ready);
    modport sink(input valid, next_x, next_y, next_heading, dx_dyaw,
                 dx_dspeed, dy_dyaw, dy_dspeed, output ready);
endinterface

/* rtl/kinematic_state_prediction_core.sv */
// ============================================================================
// kinematic_state_prediction_core : CV / yaw-rate prediction step
// Predicts position and yaw one time step ahead and gives the state-dependent
// Jacobian entries; sine/cosine from a fully pipelined CORDIC.
// ============================================================================
//  channel   dir  word
//  i_state   in   pos_x pos_y heading heading_bias speed turn_rate time_step
//  o_pred    out  next_x next_y next_heading dx_dyaw dx_dspeed dy_dyaw dy_dspeed
//
//  One word accepted per cycle while o_pred is not stalled; the pipeline is the
//  one-rotation-per-stage CORDIC plus three stages ahead and five behind it.
//  The yaw mod 2pi reduction runs alongside the first CORDIC stages.
//  Reset clears the valid bits only. A stall on o_pred freezes every stage,
//  so nothing is lost or repeated.
module kinematic_state_prediction_core #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ksp_state_if.sink      i_state,
    ksp_pred_if.source     o_pred
);
    import ksp_pkg::*;

    localparam int N = CORDIC_STEPS;
    localparam int L = N + 8;
    localparam logic [41:0] U_OFS = 42'(PI_Q28) + (42'(TWO_PI_Q28) << 9);

    logic         w_en;
    logic [L-1:0] r_vld;

    assign w_en          = !r_vld[L-1] || o_pred.ready;
    assign i_state.ready = w_en;
    assign o_pred.valid  = r_vld[L-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[L-2:0], i_state.valid};
        end
    end

    // ---------------- stage 0: input word
    logic signed [47:0] r0_px, r0_py;
    logic signed [30:0] r0_yaw, r0_bias;
    logic signed [31:0] r0_spd, r0_rate;
    logic        [31:0] r0_dt;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_px   <= i_state.pos_x;
            r0_py   <= i_state.pos_y;
            r0_yaw  <= i_state.heading;
            r0_bias <= i_state.heading_bias;
            r0_spd  <= i_state.speed;
            r0_rate <= i_state.turn_rate;
            r0_dt   <= i_state.time_step;
        end
    end

    // ---------------- stage 1: angle wrap, rate*dt, speed*dt
    logic signed [31:0] w1_sum, n1_ang;
    logic signed [64:0] w1_prd, w1_vdt;
    logic signed [31:0] r1_ang;
    logic signed [63:0] r1_prd, r1_vdt;
    logic signed [47:0] r1_px, r1_py;
    logic signed [30:0] r1_yaw;
    logic        [31:0] r1_dt;

    always_comb begin
        w1_sum = 32'(r0_yaw) + 32'(r0_bias);
        priority if (w1_sum > PI_Q28) begin
            n1_ang = w1_sum - TWO_PI_Q28;
        end else if (w1_sum < -PI_Q28) begin
            n1_ang = w1_sum + TWO_PI_Q28;
        end else begin
            n1_ang = w1_sum;
        end
        w1_prd = 65'(r0_rate) * $signed({1'b0, r0_dt});
        w1_vdt = 65'(r0_spd) * $signed({1'b0, r0_dt});
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_ang <= n1_ang;
            r1_prd <= w1_prd[63:0];
            r1_vdt <= w1_vdt[63:0];
            r1_px  <= r0_px;
            r1_py  <= r0_py;
            r1_yaw <= r0_yaw;
            r1_dt  <= r0_dt;
        end
    end

    // ---------------- stage 2: quadrant fold, yaw increment
    logic signed [33:0] w2_z4, n2_z;
    logic               n2_flip;
    logic signed [63:0] w2_rnd;
    logic signed [39:0] w2_dyaw;
    logic signed [40:0] w2_v;
    logic        [41:0] n2_u;

    always_comb begin
        w2_z4 = $signed({r1_ang[31], r1_ang, 1'b0}) <<< 1;
        priority if (w2_z4 > HALF_PI_Q30) begin
            n2_z    = w2_z4 - PI_Q30;
            n2_flip = 1'b1;
        end else if (w2_z4 < -HALF_PI_Q30) begin
            n2_z    = w2_z4 + PI_Q30;
            n2_flip = 1'b1;
        end else begin
            n2_z    = w2_z4;
            n2_flip = 1'b0;
        end
        // round half away from zero
        w2_rnd  = r1_prd + $signed((64'd1 << 23) - {63'd0, r1_prd[63]});
        w2_dyaw = w2_rnd[63:24];
        w2_v    = 41'(r1_yaw) + 41'(w2_dyaw);
        n2_u    = 42'(w2_v) + U_OFS;
    end

    logic signed [33:0] r_x [0:N];
    logic signed [33:0] r_y [0:N];
    logic signed [33:0] r_z [0:N];
    logic        [41:0] r_u [0:N];
    t_side              r_sd [0:N];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x[0]        <= GAIN_Q30;
            r_y[0]        <= '0;
            r_z[0]        <= n2_z;
            r_u[0]        <= n2_u;
            r_sd[0].px    <= r1_px;
            r_sd[0].py    <= r1_py;
            r_sd[0].vdt   <= r1_vdt;
            r_sd[0].dt    <= r1_dt;
            r_sd[0].flip  <= n2_flip;
            r_sd[0].is_pi <= (w2_v == 41'(PI_Q28));
        end
    end

    // ---------------- CORDIC rotations, one per stage
    for (genvar i = 0; i < N; i++) begin : g_rot
        localparam logic signed [33:0] ATN = 34'(ATAN_Q30[i]);
        logic signed [33:0] w_dx, w_dy;
        logic        [41:0] n_u;

        assign w_dx = r_y[i] >>> i;
        assign w_dy = r_x[i] >>> i;

        if (i < RED_STEPS) begin : g_red
            localparam logic [41:0] SUB = 42'(TWO_PI_Q28) << (RED_STEPS - 1 - i);
            assign n_u = (r_u[i] >= SUB) ? r_u[i] - SUB : r_u[i];
        end else begin : g_pass
            assign n_u = r_u[i];
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                if (!r_z[i][33]) begin
                    r_x[i+1] <= r_x[i] - w_dx;
                    r_y[i+1] <= r_y[i] + w_dy;
                    r_z[i+1] <= r_z[i] - ATN;
                end else begin
                    r_x[i+1] <= r_x[i] + w_dx;
                    r_y[i+1] <= r_y[i] - w_dy;
                    r_z[i+1] <= r_z[i] + ATN;
                end
                r_u[i+1]  <= n_u;
                r_sd[i+1] <= r_sd[i];
            end
        end
    end

    // ---------------- M0: sign restore, heading result
    logic signed [31:0] r3_c, r3_s;
    logic signed [63:0] r3_vdt;
    logic        [31:0] r3_dt;
    logic signed [47:0] r3_px, r3_py;
    logic signed [30:0] r3_hd;
    logic signed [33:0] w3_c, w3_s;
    logic        [41:0] w3_h;

    always_comb begin
        w3_c = r_sd[N].flip ? -r_x[N] : r_x[N];
        w3_s = r_sd[N].flip ? -r_y[N] : r_y[N];
        w3_h = r_u[N] - 42'(PI_Q28);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_c   <= w3_c[31:0];
            r3_s   <= w3_s[31:0];
            r3_vdt <= $signed(r_sd[N].vdt);
            r3_dt  <= r_sd[N].dt;
            r3_px  <= $signed(r_sd[N].px);
            r3_py  <= $signed(r_sd[N].py);
            r3_hd  <= r_sd[N].is_pi ? PI_Q28[30:0] : $signed(w3_h[30:0]);
        end
    end

    // ---------------- M1: partial products
    logic signed [63:0] r4_ch, r4_sh;
    logic signed [64:0] r4_cl, r4_sl, r4_cd, r4_sd;
    logic signed [47:0] r4_px, r4_py;
    logic signed [30:0] r4_hd;
    logic signed [63:0] w4_ch, w4_sh;
    logic signed [64:0] w4_cl, w4_sl, w4_cd, w4_sd;

    always_comb begin
        // upper half of speed*dt is signed, lower half unsigned
        w4_ch = 64'($signed(r3_vdt[63:32])) * 64'(r3_c);
        w4_sh = 64'($signed(r3_vdt[63:32])) * 64'(r3_s);
        w4_cl = $signed({1'b0, r3_vdt[31:0]}) * 65'(r3_c);
        w4_sl = $signed({1'b0, r3_vdt[31:0]}) * 65'(r3_s);
        w4_cd = 65'(r3_c) * $signed({1'b0, r3_dt});
        w4_sd = 65'(r3_s) * $signed({1'b0, r3_dt});
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_ch <= w4_ch;
            r4_sh <= w4_sh;
            r4_cl <= w4_cl;
            r4_sl <= w4_sl;
            r4_cd <= w4_cd;
            r4_sd <= w4_sd;
            r4_px <= r3_px;
            r4_py <= r3_py;
            r4_hd <= r3_hd;
        end
    end

    // ---------------- M2: full speed*dt*trig products
    logic signed [95:0] r5_pc, r5_ps;
    logic signed [64:0] r5_cd, r5_sd;
    logic signed [47:0] r5_px, r5_py;
    logic signed [30:0] r5_hd;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_pc <= (96'(r4_ch) <<< 32) + 96'(r4_cl);
            r5_ps <= (96'(r4_sh) <<< 32) + 96'(r4_sl);
            r5_cd <= r4_cd;
            r5_sd <= r4_sd;
            r5_px <= r4_px;
            r5_py <= r4_py;
            r5_hd <= r4_hd;
        end
    end

    // ---------------- M3: rounding and saturation
    function automatic logic signed [41:0] rnd54(input logic signed [95:0] p);
        logic signed [95:0] t;
        t = p + $signed((96'd1 << 53) - {95'd0, p[95]});
        return t[95:54];
    endfunction

    function automatic logic signed [31:0] rnd30(input logic signed [64:0] p);
        logic signed [64:0] t;
        logic signed [34:0] q;
        t = p + $signed((65'd1 << 29) - {64'd0, p[64]});
        q = t[64:30];
        priority if (q > 35'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (q < -35'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return q[31:0];
        end
    endfunction

    logic signed [47:0] r6_dc, r6_ds;
    logic signed [31:0] r6_cd, r6_sd;
    logic signed [47:0] r6_px, r6_py;
    logic signed [30:0] r6_hd;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_dc <= 48'(rnd54(r5_pc));
            r6_ds <= 48'(rnd54(r5_ps));
            r6_cd <= rnd30(r5_cd);
            r6_sd <= rnd30(r5_sd);
            r6_px <= r5_px;
            r6_py <= r5_py;
            r6_hd <= r5_hd;
        end
    end

    // ---------------- M4: position update, output word
    function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
        priority if (v > 49'sh0_7FFF_FFFF_FFFF) begin
            return 48'sh7FFF_FFFF_FFFF;
        end else if (v < -49'sh0_8000_0000_0000) begin
            return 48'sh8000_0000_0000;
        end else begin
            return v[47:0];
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_pred.next_x       <= sat48(49'(r6_px) + 49'(r6_dc));
            o_pred.next_y       <= sat48(49'(r6_py) + 49'(r6_ds));
            o_pred.next_heading <= r6_hd;
            o_pred.dx_dyaw      <= sat48(-49'(r6_ds));
            o_pred.dx_dspeed    <= r6_cd;
            o_pred.dy_dyaw      <= r6_dc;
            o_pred.dy_dspeed    <= r6_sd;
        end
    end

endmodule
